FILE: rtl/mfs_pkg.sv
// Shared codes and types of the multi-stream frame sync block.
package mfs_pkg;

  localparam int STREAM_W = 2;
  localparam int INDEX_W  = 32;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;
  localparam int CFG_AW   = 1;
  localparam int CFG_DW   = 3;
  localparam int ACT_W    = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_NEW    = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_EN = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DISABLED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_HOLDER_EN = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_ACTIVE    = 1'd1;

  // Slot kind of a frame store access
  localparam logic KIND_PEND = 1'b0;
  localparam logic KIND_SYNC = 1'b1;

  typedef struct packed {
    logic vld;
    logic kind;
  } mfs_rd_req_t;

  typedef enum logic [5:0] {
    FSM_IDLE   = 6'b000001,
    FSM_DISP   = 6'b000010,
    FSM_SCAN   = 6'b000100,
    FSM_DRAIN  = 6'b001000,
    FSM_DECIDE = 6'b010000,
    FSM_DONE   = 6'b100000
  } mfs_state_e;

endpackage

FILE: rtl/mfs_frame_store.sv
// Frame store: two frame slots per stream in one memory, with a swap bit per stream.
module mfs_frame_store #(
  parameter int MAX_STREAMS = 4,
  parameter int TAG_BITS    = 16,
  localparam int SW         = $clog2(MAX_STREAMS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mfs_pkg::mfs_rd_req_t         rd_req_i,
  input  logic [SW-1:0]                rd_stream_i,
  input  logic                         wr_en_i,
  input  logic [SW-1:0]                wr_stream_i,
  input  logic [TAG_BITS-1:0]          wr_tag_i,
  input  logic [mfs_pkg::INDEX_W-1:0]  wr_index_i,
  input  logic [MAX_STREAMS-1:0]       flip_i,
  output mfs_pkg::mfs_rd_req_t         rsp_o,
  output logic [SW-1:0]                rsp_stream_o,
  output logic [TAG_BITS-1:0]          rsp_tag_o,
  output logic [mfs_pkg::INDEX_W-1:0]  rsp_index_o
);

  localparam int WW    = TAG_BITS + mfs_pkg::INDEX_W;
  localparam int DEPTH = 2 * MAX_STREAMS;

  logic [WW-1:0]          mem [DEPTH];
  logic [MAX_STREAMS-1:0] sel_q;
  logic [WW-1:0]          rdata_q;
  logic [SW:0]            rd_addr, wr_addr;

  // sel_q[i] names the slot that holds the pending frame; the other is synced
  assign rd_addr = {rd_stream_i, sel_q[rd_stream_i] ^ rd_req_i.kind};
  assign wr_addr = {wr_stream_i, sel_q[wr_stream_i]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q        <= '0;
      rsp_o        <= '0;
      rsp_stream_o <= '0;
    end else begin
      sel_q        <= sel_q ^ flip_i;
      rsp_o        <= rd_req_i;
      rsp_stream_o <= rd_stream_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr] <= {wr_tag_i, wr_index_i};
    end
    if (rd_req_i.vld) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign rsp_tag_o   = rdata_q[WW-1:mfs_pkg::INDEX_W];
  assign rsp_index_o = rdata_q[mfs_pkg::INDEX_W-1:0];

endmodule

FILE: rtl/multi_stream_frame_sync.sv
// Top level of the multi-stream frame sync block: sequencer, stream flags, result register.
//
//   channel  signals                                   direction  handshake
//   in       opcode/stream/frame_index/frame_tag/enable in        in_valid_i / in_ready_o
//   out      status/frame_valid/out_tag/out_index/latched out      out_valid_o / out_ready_i
//   cfg      cfg_addr_i / cfg_wdata_i                   in        cfg_we_i, no wait
//
// New frame, read and peek that pass their checks go through scan, drain and decide before
// the result is loaded; one memory read per cycle scans both slots of each group stream.
// Other operations, and those answered without a scan, go from dispatch straight to done.
// The next transaction is taken in the cycle after the result loads; one is in work at a time.
// Reset clears all flags and the swap bits; frame store contents stay undefined.
// A result waits in the output register; the next result holds until it is taken.
module multi_stream_frame_sync #(
  parameter int MAX_STREAMS = 4,
  parameter int TAG_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mfs_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [mfs_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mfs_pkg::OP_W-1:0]      opcode_i,
  input  logic [mfs_pkg::STREAM_W-1:0]  stream_i,
  input  logic [mfs_pkg::INDEX_W-1:0]   frame_index_i,
  input  logic [TAG_BITS-1:0]           frame_tag_i,
  input  logic                          enable_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mfs_pkg::STAT_W-1:0]    status_o,
  output logic                          frame_valid_o,
  output logic [TAG_BITS-1:0]           out_tag_o,
  output logic [mfs_pkg::INDEX_W-1:0]   out_index_o,
  output logic                          latched_o
);

  localparam int SW = $clog2(MAX_STREAMS);
  localparam int CW = $clog2(MAX_STREAMS + 1);
  localparam int IW = mfs_pkg::INDEX_W;

  mfs_pkg::mfs_state_e state_q, state_d;

  logic                          hen_q, hen_d;
  logic [mfs_pkg::ACT_W-1:0]     act_q, act_d;
  logic [MAX_STREAMS-1:0]        pv_q, pv_d, sv_q, sv_d, se_q, se_d;

  logic [mfs_pkg::OP_W-1:0]      op_q, op_d;
  logic [mfs_pkg::STREAM_W-1:0]  s_q, s_d;
  logic [IW-1:0]                 fidx_q, fidx_d;
  logic [TAG_BITS-1:0]           ftag_q, ftag_d;
  logic                          en_q, en_d;

  logic [SW:0]                   cnt_q, cnt_d;
  logic                          ref_ok_q, ref_ok_d;
  logic [IW-1:0]                 ref_idx_q, ref_idx_d;
  logic [CW-1:0]                 vcnt_q, vcnt_d, scnt_q, scnt_d;
  logic                          max_ok_q, max_ok_d;
  logic [IW-1:0]                 max_q, max_d;
  logic                          take_pend_q, take_pend_d;

  logic [mfs_pkg::STAT_W-1:0]    res_status_q, res_status_d;
  logic                          res_fv_q, res_fv_d;
  logic [TAG_BITS-1:0]           res_tag_q, res_tag_d;
  logic [IW-1:0]                 res_idx_q, res_idx_d;
  logic                          res_lat_q, res_lat_d;

  logic                          out_valid_q, out_valid_d;
  logic [mfs_pkg::STAT_W-1:0]    out_status_q, out_status_d;
  logic                          out_fv_q, out_fv_d;
  logic [TAG_BITS-1:0]           out_tag_q, out_tag_d;
  logic [IW-1:0]                 out_idx_q, out_idx_d;
  logic                          out_lat_q, out_lat_d;

  logic [CW-1:0]                 grp_n;
  logic [MAX_STREAMS-1:0]        grp_mask;
  logic [SW-1:0]                 si;
  logic                          s_in_rng;
  logic [SW:0]                   last_cnt;

  mfs_pkg::mfs_rd_req_t          rd_req, rsp;
  logic                          mem_we;
  logic [MAX_STREAMS-1:0]        flip;
  logic [SW-1:0]                 rsp_stream;
  logic [TAG_BITS-1:0]           rsp_tag;
  logic [IW-1:0]                 rsp_idx;

  // Group size, clamped to 1..MAX_STREAMS
  always_comb begin
    if (act_q == '0) begin
      grp_n = CW'(1);
    end else if (32'(act_q) > 32'(MAX_STREAMS)) begin
      grp_n = CW'(MAX_STREAMS);
    end else begin
      grp_n = CW'(act_q);
    end
    for (int i = 0; i < MAX_STREAMS; i++) begin
      grp_mask[i] = 32'(i) < 32'(grp_n);
    end
  end

  assign si       = SW'(s_q);
  assign s_in_rng = 32'(s_q) < 32'(grp_n);
  assign last_cnt = {SW'(grp_n - CW'(1)), 1'b1};

  mfs_frame_store #(
    .MAX_STREAMS (MAX_STREAMS),
    .TAG_BITS    (TAG_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_req_i     (rd_req),
    .rd_stream_i  (cnt_q[SW:1]),
    .wr_en_i      (mem_we),
    .wr_stream_i  (si),
    .wr_tag_i     (ftag_q),
    .wr_index_i   (fidx_q),
    .flip_i       (flip),
    .rsp_o        (rsp),
    .rsp_stream_o (rsp_stream),
    .rsp_tag_o    (rsp_tag),
    .rsp_index_o  (rsp_idx)
  );

  always_comb begin
    logic                   lat;
    logic                   clr;
    logic                   is_s;
    logic                   eff;
    logic                   match;
    logic [MAX_STREAMS-1:0] pv_n;
    logic [MAX_STREAMS-1:0] sv_n;

    lat   = 1'b0;
    clr   = 1'b0;
    is_s  = 1'b0;
    eff   = 1'b0;
    match = 1'b0;
    pv_n  = pv_q;
    sv_n  = sv_q;

    state_d      = state_q;
    hen_d        = hen_q;
    act_d        = act_q;
    pv_d         = pv_q;
    sv_d         = sv_q;
    se_d         = se_q;
    op_d         = op_q;
    s_d          = s_q;
    fidx_d       = fidx_q;
    ftag_d       = ftag_q;
    en_d         = en_q;
    cnt_d        = cnt_q;
    ref_ok_d     = ref_ok_q;
    ref_idx_d    = ref_idx_q;
    vcnt_d       = vcnt_q;
    scnt_d       = scnt_q;
    max_ok_d     = max_ok_q;
    max_d        = max_q;
    take_pend_d  = take_pend_q;
    res_status_d = res_status_q;
    res_fv_d     = res_fv_q;
    res_tag_d    = res_tag_q;
    res_idx_d    = res_idx_q;
    res_lat_d    = res_lat_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_fv_d     = out_fv_q;
    out_tag_d    = out_tag_q;
    out_idx_d    = out_idx_q;
    out_lat_d    = out_lat_q;
    rd_req       = '0;
    mem_we       = 1'b0;
    flip         = '0;

    if (cfg_we_i) begin
      case (cfg_addr_i)
        mfs_pkg::CFG_HOLDER_EN: hen_d = cfg_wdata_i[0];
        mfs_pkg::CFG_ACTIVE:    act_d = cfg_wdata_i[mfs_pkg::ACT_W-1:0];
        default: ;
      endcase
    end

    // Fold returning frame store data into the scan accumulators
    if (rsp.vld) begin
      is_s = rsp_stream == si;
      if (rsp.kind == mfs_pkg::KIND_PEND) begin
        case (op_q)
          mfs_pkg::OP_NEW: begin
            if (!is_s && pv_q[rsp_stream] && rsp_idx == fidx_q) begin
              vcnt_d = vcnt_q + CW'(1);
            end
          end
          mfs_pkg::OP_READ: begin
            if (rsp_stream == '0) begin
              ref_idx_d = rsp_idx;
            end
            eff   = pv_q[rsp_stream] && !(is_s && take_pend_q);
            match = (rsp_stream == '0) || (rsp_idx == ref_idx_q);
            if (is_s && take_pend_q) begin
              vcnt_d    = vcnt_q + CW'(1);
              res_tag_d = rsp_tag;
              res_idx_d = rsp_idx;
            end else if (eff && ref_ok_q && match) begin
              vcnt_d = vcnt_q + CW'(1);
            end
          end
          default: ;
        endcase
      end else begin
        case (op_q)
          mfs_pkg::OP_NEW: begin
            if (sv_q[rsp_stream]) begin
              scnt_d = scnt_q + CW'(1);
            end
          end
          mfs_pkg::OP_READ: begin
            if (is_s) begin
              if (!take_pend_q) begin
                res_tag_d = rsp_tag;
                res_idx_d = rsp_idx;
              end
            end else if (sv_q[rsp_stream]) begin
              if (!max_ok_q || max_q < rsp_idx) begin
                max_d = rsp_idx;
              end
              max_ok_d = 1'b1;
            end
          end
          mfs_pkg::OP_PEEK: begin
            if (is_s) begin
              res_tag_d = rsp_tag;
              res_idx_d = rsp_idx;
            end
          end
          default: ;
        endcase
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      mfs_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          s_d     = stream_i;
          fidx_d  = frame_index_i;
          ftag_d  = frame_tag_i;
          en_d    = enable_value_i;
          state_d = mfs_pkg::FSM_DISP;
        end
      end
      mfs_pkg::FSM_DISP: begin
        res_status_d = mfs_pkg::STAT_OK;
        res_fv_d     = 1'b0;
        res_tag_d    = '0;
        res_idx_d    = '0;
        res_lat_d    = 1'b0;
        vcnt_d       = '0;
        scnt_d       = '0;
        max_ok_d     = 1'b0;
        max_d        = '0;
        ref_ok_d     = pv_q[0];
        ref_idx_d    = '0;
        take_pend_d  = !sv_q[si];
        cnt_d        = '0;
        state_d      = mfs_pkg::FSM_DONE;
        if (op_q <= mfs_pkg::OP_SET_EN && !s_in_rng) begin
          res_status_d = mfs_pkg::STAT_RANGE;
        end else begin
          case (op_q)
            mfs_pkg::OP_NEW: begin
              if (hen_q) begin
                pv_d[si] = se_q[si];
                mem_we   = se_q[si];
                vcnt_d   = se_q[si] ? CW'(1) : CW'(0);
                state_d  = mfs_pkg::FSM_SCAN;
              end
            end
            mfs_pkg::OP_READ: begin
              if (!hen_q) begin
                res_status_d = mfs_pkg::STAT_DISABLED;
              end else if (!sv_q[si] && !pv_q[si]) begin
                res_status_d = mfs_pkg::STAT_EMPTY;
              end else begin
                res_fv_d = 1'b1;
                state_d  = mfs_pkg::FSM_SCAN;
              end
            end
            mfs_pkg::OP_PEEK: begin
              if (!hen_q) begin
                res_status_d = mfs_pkg::STAT_DISABLED;
              end else if (!sv_q[si]) begin
                res_status_d = mfs_pkg::STAT_EMPTY;
              end else begin
                res_fv_d = 1'b1;
                state_d  = mfs_pkg::FSM_SCAN;
              end
            end
            mfs_pkg::OP_SET_EN: begin
              se_d[si] = en_q;
              if (!en_q) begin
                pv_d[si] = 1'b0;
                sv_d[si] = 1'b0;
              end
            end
            mfs_pkg::OP_CLEAR: begin
              pv_d = '0;
              sv_d = '0;
            end
            default: ;
          endcase
        end
      end
      mfs_pkg::FSM_SCAN: begin
        // Both slots of each group stream, pending first
        rd_req.vld  = 1'b1;
        rd_req.kind = cnt_q[0];
        cnt_d       = cnt_q + (SW+1)'(1);
        if (cnt_q == last_cnt) begin
          state_d = mfs_pkg::FSM_DRAIN;
        end
      end
      mfs_pkg::FSM_DRAIN: begin
        state_d = mfs_pkg::FSM_DECIDE;
      end
      mfs_pkg::FSM_DECIDE: begin
        case (op_q)
          mfs_pkg::OP_NEW: begin
            lat = (scnt_q == '0 || scnt_q == grp_n) && vcnt_q == grp_n;
          end
          mfs_pkg::OP_READ: begin
            if (take_pend_q) begin
              pv_n[si] = 1'b0;
            end else begin
              sv_n[si] = 1'b0;
            end
            // Drop stale synced frames of the whole group
            clr = max_ok_q && res_idx_q != max_q;
            if (clr) begin
              sv_n = sv_n & ~grp_mask;
            end
            lat = !(max_ok_q && !clr) && vcnt_q == grp_n;
          end
          default: ;
        endcase
        if (lat) begin
          sv_n = (sv_n & ~grp_mask) | (pv_n & grp_mask);
          pv_n = pv_n & ~grp_mask;
          flip = grp_mask;
        end
        pv_d      = pv_n;
        sv_d      = sv_n;
        res_lat_d = lat;
        state_d   = mfs_pkg::FSM_DONE;
      end
      mfs_pkg::FSM_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_fv_d     = res_fv_q;
          out_tag_d    = res_tag_q;
          out_idx_d    = res_idx_q;
          out_lat_d    = res_lat_q;
          state_d      = mfs_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = mfs_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfs_pkg::FSM_IDLE;
      hen_q       <= 1'b1;
      act_q       <= mfs_pkg::ACT_W'(2);
      pv_q        <= '0;
      sv_q        <= '0;
      se_q        <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      hen_q       <= hen_d;
      act_q       <= act_d;
      pv_q        <= pv_d;
      sv_q        <= sv_d;
      se_q        <= se_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    s_q          <= s_d;
    fidx_q       <= fidx_d;
    ftag_q       <= ftag_d;
    en_q         <= en_d;
    ref_ok_q     <= ref_ok_d;
    ref_idx_q    <= ref_idx_d;
    vcnt_q       <= vcnt_d;
    scnt_q       <= scnt_d;
    max_ok_q     <= max_ok_d;
    max_q        <= max_d;
    take_pend_q  <= take_pend_d;
    res_status_q <= res_status_d;
    res_fv_q     <= res_fv_d;
    res_tag_q    <= res_tag_d;
    res_idx_q    <= res_idx_d;
    res_lat_q    <= res_lat_d;
    out_status_q <= out_status_d;
    out_fv_q     <= out_fv_d;
    out_tag_q    <= out_tag_d;
    out_idx_q    <= out_idx_d;
    out_lat_q    <= out_lat_d;
  end

  assign in_ready_o    = state_q == mfs_pkg::FSM_IDLE;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign frame_valid_o = out_fv_q;
  assign out_tag_o     = out_tag_q;
  assign out_index_o   = out_idx_q;
  assign latched_o     = out_lat_q;

endmodule

FILE: dv/multi_stream_frame_sync_test.sv
// Self-checking testbench of the multi-stream frame sync block with a built-in predictor.
`timescale 1ns / 1ps

module multi_stream_frame_sync_test;
  import mfs_pkg::*;

  localparam int STREAMS   = 4;
  localparam int TAG_W     = 16;
  localparam int WDOG_LIMIT = 2000;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               frame_valid;
    logic [TAG_W-1:0]   tag;
    logic [INDEX_W-1:0] index;
    logic               latched;
  } sync_result_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr_i     = '0;
  logic [CFG_DW-1:0]   cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     opcode_i       = '0;
  logic [STREAM_W-1:0] stream_i       = '0;
  logic [INDEX_W-1:0]  frame_index_i  = '0;
  logic [TAG_W-1:0]    frame_tag_i    = '0;
  logic                enable_value_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic                frame_valid_o;
  logic [TAG_W-1:0]    out_tag_o;
  logic [INDEX_W-1:0]  out_index_o;
  logic                latched_o;

  multi_stream_frame_sync #(
    .MAX_STREAMS(STREAMS),
    .TAG_BITS   (TAG_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .stream_i      (stream_i),
    .frame_index_i (frame_index_i),
    .frame_tag_i   (frame_tag_i),
    .enable_value_i(enable_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .frame_valid_o (frame_valid_o),
    .out_tag_o     (out_tag_o),
    .out_index_o   (out_index_o),
    .latched_o     (latched_o)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic                m_holder_en = 1'b1;
  logic [CFG_DW-1:0]   m_active    = 3'd2;
  logic [STREAMS-1:0]  pend_v      = '0;
  logic [STREAMS-1:0]  sync_v      = '0;
  logic [STREAMS-1:0]  strm_en     = '0;
  logic [TAG_W-1:0]    pend_tag [STREAMS];
  logic [TAG_W-1:0]    sync_tag [STREAMS];
  logic [INDEX_W-1:0]  pend_idx [STREAMS];
  logic [INDEX_W-1:0]  sync_idx [STREAMS];

  sync_result_t        sync_answers [$];
  int                  ops_sent       = 0;
  int                  mismatches     = 0;
  int                  idle_cycles    = 0;
  int                  rx_hold_cycles = 0;
  int                  rx_stall_left  = 0;
  bit                  tx_idle_on     = 1'b1;
  bit                  rx_idle_on     = 1'b1;
  logic [INDEX_W-1:0]  last_index     = '0;

  initial begin
    for (int i = 0; i < STREAMS; i++) begin
      pend_tag[i] = '0;
      sync_tag[i] = '0;
      pend_idx[i] = '0;
      sync_idx[i] = '0;
    end
  end

  function automatic int streams_in_group();
    if (m_active == 0) return 1;
    if (m_active > STREAMS) return STREAMS;
    return int'(m_active);
  endfunction

  function automatic void promote_pending(input int n);
    for (int i = 0; i < n; i++) begin
      sync_v[i]   = pend_v[i];
      sync_tag[i] = pend_tag[i];
      sync_idx[i] = pend_idx[i];
      pend_v[i]   = 1'b0;
    end
  endfunction

  function automatic logic store_new_frame(input int s, input logic [INDEX_W-1:0] idx,
                                           input logic [TAG_W-1:0] tag, input int n);
    int match_cnt;
    int sync_cnt;
    match_cnt = 1;
    sync_cnt  = 0;
    for (int i = 0; i < n; i++) begin
      if (i == s) begin
        pend_v[i] = 1'b0;
        if (strm_en[i]) begin
          pend_v[i]   = 1'b1;
          pend_tag[i] = tag;
          pend_idx[i] = idx;
        end else begin
          match_cnt--;
        end
      end else if (pend_v[i] && pend_idx[i] == idx) begin
        match_cnt++;
      end
      if (sync_v[i]) sync_cnt++;
    end
    if ((sync_cnt == 0 || sync_cnt == n) && match_cnt == n) begin
      promote_pending(n);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Hand out the synced frame first, else the pending one; drop stale synced frames.
  function automatic logic hand_out_frame(input int s, input int n,
                                          output logic [TAG_W-1:0] otag,
                                          output logic [INDEX_W-1:0] oidx);
    logic               ref_ok;
    logic [INDEX_W-1:0] ref_idx;
    logic               max_ok;
    logic [INDEX_W-1:0] max_idx;
    logic               sync_left;
    int                 match_cnt;
    ref_ok    = pend_v[0];
    ref_idx   = pend_idx[0];
    max_ok    = 1'b0;
    max_idx   = '0;
    sync_left = 1'b0;
    match_cnt = 0;
    otag      = '0;
    oidx      = '0;
    for (int i = 0; i < n; i++) begin
      if (i == s) begin
        if (sync_v[i]) begin
          otag      = sync_tag[i];
          oidx      = sync_idx[i];
          sync_v[i] = 1'b0;
        end else begin
          otag      = pend_tag[i];
          oidx      = pend_idx[i];
          pend_v[i] = 1'b0;
          match_cnt++;
        end
      end else if (sync_v[i]) begin
        if (!max_ok || max_idx < sync_idx[i]) max_idx = sync_idx[i];
        max_ok    = 1'b1;
        sync_left = 1'b1;
      end
      if (pend_v[i] && ref_ok && pend_idx[i] == ref_idx) match_cnt++;
    end
    if (max_ok && oidx != max_idx) begin
      for (int i = 0; i < n; i++) sync_v[i] = 1'b0;
      sync_left = 1'b0;
    end
    if (!sync_left && match_cnt == n) begin
      promote_pending(n);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic sync_result_t predict_sync_op(input logic [OP_W-1:0] op,
                                                   input logic [STREAM_W-1:0] s,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic [TAG_W-1:0] tag,
                                                   input logic en);
    sync_result_t       r;
    int                 n;
    logic [TAG_W-1:0]   otag;
    logic [INDEX_W-1:0] oidx;
    n = streams_in_group();
    r = '0;
    if (op <= OP_SET_EN && int'(s) >= n) begin
      r.status = STAT_RANGE;
    end else if (op == OP_NEW) begin
      if (m_holder_en) r.latched = store_new_frame(int'(s), idx, tag, n);
    end else if (op == OP_READ) begin
      if (!m_holder_en) begin
        r.status = STAT_DISABLED;
      end else if (!sync_v[s] && !pend_v[s]) begin
        r.status = STAT_EMPTY;
      end else begin
        r.latched     = hand_out_frame(int'(s), n, otag, oidx);
        r.frame_valid = 1'b1;
        r.tag         = otag;
        r.index       = oidx;
      end
    end else if (op == OP_PEEK) begin
      if (!m_holder_en) begin
        r.status = STAT_DISABLED;
      end else if (!sync_v[s]) begin
        r.status = STAT_EMPTY;
      end else begin
        r.frame_valid = 1'b1;
        r.tag         = sync_tag[s];
        r.index       = sync_idx[s];
      end
    end else if (op == OP_SET_EN) begin
      strm_en[s] = en;
      if (!en) begin
        pend_v[s] = 1'b0;
        sync_v[s] = 1'b0;
      end
    end else if (op == OP_CLEAR) begin
      pend_v = '0;
      sync_v = '0;
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    case ($urandom_range(0, 3))
      0:       last_index = last_index + 1;
      1:       last_index = last_index;
      default: last_index = $urandom;
    endcase
    return last_index;
  endfunction

  task automatic issue_op(input logic [OP_W-1:0] op, input logic [STREAM_W-1:0] s,
                          input logic [INDEX_W-1:0] idx, input logic [TAG_W-1:0] tag,
                          input logic en);
    int gap;
    gap = tx_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    stream_i       <= s;
    frame_index_i  <= idx;
    frame_tag_i    <= tag;
    enable_value_i <= en;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sync_answers.push_back(predict_sync_op(op, s, idx, tag, en));
    ops_sent++;
  endtask

  // Drop valid, let every result arrive, then let the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sync_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == CFG_HOLDER_EN) m_holder_en = data[0];
    else m_active = data;
    @(posedge clk_i);
  endtask

  task automatic random_op();
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    int                 r;
    r = $urandom_range(0, 15);
    if (r < 4) op = OP_NEW;
    else if (r < 8) op = OP_READ;
    else if (r < 11) op = OP_PEEK;
    else if (r < 13) op = OP_SET_EN;
    else if (r < 14) op = OP_CLEAR;
    else op = OP_W'($urandom_range(int'(OP_CLEAR) + 1, (1 << OP_W) - 1));
    idx = $urandom_range(0, 1) ? last_index : INDEX_W'($urandom);
    issue_op(op, STREAM_W'($urandom_range(0, 3)), idx, TAG_W'($urandom),
             $urandom_range(0, 3) != 0);
  endtask

  // One well-formed frame set across the group, optionally followed by peeks and reads.
  task automatic frame_round();
    int                 n;
    int                 j;
    int                 tmp;
    int                 order [STREAMS];
    logic [INDEX_W-1:0] idx;
    n = streams_in_group();
    for (int k = 0; k < n; k++) begin
      if (!strm_en[k]) issue_op(OP_SET_EN, STREAM_W'(k), INDEX_W'($urandom), TAG_W'($urandom),
                                1'b1);
    end
    idx = pick_index();
    for (int k = 0; k < STREAMS; k++) order[k] = k;
    for (int k = n - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < n; k++) begin
      issue_op(OP_NEW, STREAM_W'(order[k]), idx, TAG_W'($urandom), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0) random_op();
    end
    // Leave some sets synced so the next set piles up behind them.
    if ($urandom_range(0, 2) != 0) begin
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 3) == 0)
          issue_op(OP_PEEK, STREAM_W'(order[n - 1 - k]), INDEX_W'($urandom),
                   TAG_W'($urandom), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 5) != 0)
          issue_op(OP_READ, STREAM_W'(order[n - 1 - k]), INDEX_W'($urandom),
                   TAG_W'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Write one of the two slots of every stream once; the other slot stays unwritten.
  task automatic test_store_init();
    write_reg(CFG_ACTIVE, CFG_DW'(4));
    for (int k = 0; k < STREAMS; k++) issue_op(OP_SET_EN, STREAM_W'(k), '0, '0, 1'b1);
    issue_op(OP_NEW, 2'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    issue_op(OP_NEW, 2'd1, 32'hFFFF_FFFF, 16'h0000, 1'b1);
    issue_op(OP_NEW, 2'd2, 32'hFFFF_FFFF, 16'h5A5A, 1'b0);
    issue_op(OP_NEW, 2'd3, 32'hFFFF_FFFF, 16'hA5A5, 1'b1);
    issue_op(OP_CLEAR, 2'd3, '0, '0, 1'b0);
  endtask

  task automatic test_group_size_limits();
    wait_idle();
    write_reg(CFG_ACTIVE, CFG_DW'(0));
    issue_op(OP_NEW, 2'd0, 32'h0000_0000, 16'h0000, 1'b0);
    issue_op(OP_READ, 2'd0, '0, '0, 1'b0);
    issue_op(OP_NEW, 2'd1, 32'h8000_0001, 16'h8001, 1'b0);
    wait_idle();
    write_reg(CFG_ACTIVE, CFG_DW'(7));
    issue_op(OP_PEEK, 2'd3, '0, '0, 1'b0);
  endtask

  task automatic test_holder_disabled();
    wait_idle();
    write_reg(CFG_HOLDER_EN, CFG_DW'(0));
    issue_op(OP_NEW, 2'd0, 32'h1234_5678, 16'h1234, 1'b0);
    issue_op(OP_READ, 2'd0, '0, '0, 1'b0);
    issue_op(OP_PEEK, 2'd0, '0, '0, 1'b0);
    issue_op(OP_SET_EN, 2'd1, '0, '0, 1'b1);
    for (int c = int'(OP_CLEAR) + 1; c < (1 << OP_W); c++)
      issue_op(OP_W'(c), STREAM_W'(c), INDEX_W'($urandom), TAG_W'($urandom), 1'b1);
    wait_idle();
    write_reg(CFG_HOLDER_EN, CFG_DW'(1));
  endtask

  task automatic test_corner_ops();
    wait_idle();
    write_reg(CFG_ACTIVE, CFG_DW'(2));
    issue_op(OP_READ, 2'd3, '0, '0, 1'b0);
    issue_op(OP_PEEK, 2'd0, '0, '0, 1'b0);
    issue_op(OP_SET_EN, 2'd1, '0, '0, 1'b0);
    issue_op(OP_NEW, 2'd1, 32'h0000_00AA, 16'h00AA, 1'b0);
    issue_op(OP_NEW, 2'd0, 32'h0000_00BB, 16'h00BB, 1'b0);
    issue_op(OP_READ, 2'd1, '0, '0, 1'b0);
    issue_op(OP_SET_EN, 2'd1, '0, '0, 1'b1);
    issue_op(OP_READ, 2'd0, '0, '0, 1'b0);
    issue_op(OP_NEW, 2'd1, 32'h0000_00CC, 16'h00CC, 1'b0);
    // stream 0 holds nothing here, so nothing counts as matching
    issue_op(OP_READ, 2'd1, '0, '0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int ph_active [9] = '{4, 3, 1, 2, 0, 7, 4, 4, 2};
    int ph_holder [9] = '{1, 1, 1, 1, 1, 1, 0, 1, 1};
    int goal;
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      write_reg(CFG_HOLDER_EN, CFG_DW'(ph_holder[p]));
      write_reg(CFG_ACTIVE, CFG_DW'(ph_active[p]));
      tx_idle_on = (p % 3) != 2;
      rx_idle_on = (p % 4) != 3;
      goal = ops_sent + (ph_holder[p] != 0 ? 115 : 20);
      while (ops_sent < goal) begin
        if (ph_holder[p] != 0 && $urandom_range(0, 3) != 0) frame_round();
        else random_op();
      end
    end
  endtask

  // Hold the output side off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    wait_idle();
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_cycles = 150;
    for (int k = 0; k < 4; k++) frame_round();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Result side: check each transaction, then pick next ready.
  always @(posedge clk_i) begin
    sync_result_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sync_answers.size() == 0) begin
        $error("result with nothing expected: status %0d", status_o);
        mismatches++;
      end else begin
        exp = sync_answers.pop_front();
        if (status_o !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status_o);
          mismatches++;
        end
        if (frame_valid_o !== exp.frame_valid) begin
          $error("frame_valid: expected %0d, got %0d", exp.frame_valid, frame_valid_o);
          mismatches++;
        end
        if (out_tag_o !== exp.tag) begin
          $error("out_tag: expected %0h, got %0h", exp.tag, out_tag_o);
          mismatches++;
        end
        if (out_index_o !== exp.index) begin
          $error("out_index: expected %0h, got %0h", exp.index, out_index_o);
          mismatches++;
        end
        if (latched_o !== exp.latched) begin
          $error("latched: expected %0d, got %0d", exp.latched, latched_o);
          mismatches++;
        end
      end
    end
    if (rx_hold_cycles > 0) begin
      rx_stall_left  = rx_hold_cycles;
      rx_hold_cycles = 0;
    end
    if (rx_stall_left > 0) begin
      out_ready_i <= 1'b0;
      rx_stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (rx_idle_on && $urandom_range(0, 3) == 0) rx_stall_left = idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("multi_stream_frame_sync test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_store_init();
    test_group_size_limits();
    test_holder_disabled();
    test_corner_ops();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && sync_answers.size() == 0) begin
      $display("multi_stream_frame_sync test passed");
    end else begin
      $display("multi_stream_frame_sync test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mfs_pkg.sv
rtl/mfs_frame_store.sv
rtl/multi_stream_frame_sync.sv
dv/multi_stream_frame_sync_test.sv
